FILE: rtl/cesq_pkg.sv
package cesq_pkg;

  localparam int TIMER_BITS_DEF = 32;
  localparam int FRAME_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOOT_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKUP_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKUP_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKUP_EVERY  = 3'd5;

  localparam logic [15:0] FRAME_TOTAL_RST = 16'd1;
  localparam logic [31:0] EXPOSURE_RST    = 32'd1000;

  typedef enum logic [2:0] {
    PH_READY  = 3'd0,
    PH_LDELAY = 3'd1,
    PH_LOCKUP = 3'd2,
    PH_SDELAY = 3'd3,
    PH_EXPOSE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_ABORT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_OK    = 2'd1,
    DONE_ABORT = 2'd2
  } done_t;

  typedef struct packed {
    logic [1:0] op;
    logic       camera_ready;
    logic       lockup_ok;
    logic       shoot_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] frame_index;
    logic        cmd_init;
    logic        cmd_start_lockup;
    logic        cmd_start_shoot;
    logic        cmd_end_shoot;
    logic        cmd_term_lockup;
    logic        cmd_term_shoot;
    logic [1:0]  frame_done;
    logic        sequence_end;
  } rsp_t;

  typedef struct packed {
    logic [15:0] frame_total;
    logic [31:0] exposure_ms;
    logic [31:0] shoot_delay_ms;
    logic [31:0] lockup_delay_ms;
    logic        lockup_enable;
    logic        lockup_every_frame;
  } cfg_t;

endpackage

FILE: rtl/camera_exposure_sequencer.sv
// An accepted beat is held in the input register, then presented from the result register.
// Throughput: one beat per cycle while the result is not stalled; the input register
// and the result register form a two-stage path with the sequencer state updated
// between them. Reset (rst, synchronous, active high) empties both stages, returns the
// sequencer to ready with the timer and frame counter cleared, and loads the register
// defaults.
module camera_exposure_sequencer
  import cesq_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data
);

  cfg_t cfg;
  req_t req_q;
  logic req_q_valid;
  rsp_t rsp_next;
  logic rsp_free;
  logic advance;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign advance   = req_q_valid && rsp_free;
  assign req_stall = req_q_valid && !rsp_free;

  cesq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cesq_step #(
    .TIMER_BITS (TIMER_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req_q),
    .cfg     (cfg),
    .rsp     (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (!req_stall) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= req_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= rsp_next;
    end
  end

  // The mirror lockup phase never survives the step that enters it.
  a_no_lockup_rest: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.phase != PH_LOCKUP)
    else $error("sequencer left in lockup phase");

  // A shutter open that does not lead to exposing is a failure that ends the sequence.
  a_shoot_fail_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.cmd_start_shoot && rsp_data.phase != PH_EXPOSE
    |-> rsp_data.sequence_end && rsp_data.cmd_term_shoot)
    else $error("failed exposure start did not end the sequence");

  // A finished frame that leaves the block ready must close the sequence.
  a_last_frame_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.phase == PH_READY && rsp_data.frame_done != DONE_NONE
    |-> rsp_data.sequence_end)
    else $error("frame ended in ready without sequence end");

  // A held input beat means the result register is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall && req_q_valid)
    else $error("input stalled without a blocked result");

endmodule

FILE: rtl/cesq_cfg.sv
module cesq_cfg
  import cesq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_total        <= FRAME_TOTAL_RST;
      cfg.exposure_ms        <= EXPOSURE_RST;
      cfg.shoot_delay_ms     <= '0;
      cfg.lockup_delay_ms    <= '0;
      cfg.lockup_enable      <= 1'b0;
      cfg.lockup_every_frame <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_TOTAL:   cfg.frame_total        <= cfg_data[15:0];
        CFG_EXPOSURE:      cfg.exposure_ms        <= cfg_data;
        CFG_SHOOT_DELAY:   cfg.shoot_delay_ms     <= cfg_data;
        CFG_LOCKUP_DELAY:  cfg.lockup_delay_ms    <= cfg_data;
        CFG_LOCKUP_ENABLE: cfg.lockup_enable      <= cfg_data[0];
        CFG_LOCKUP_EVERY:  cfg.lockup_every_frame <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/cesq_step.sv
module cesq_step
  import cesq_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t rsp
);

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  phase_t                phase;
  phase_t                phase_next;
  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic [FRAME_BITS-1:0] count;
  logic [FRAME_BITS-1:0] count_next;

  logic enter_stage;
  logic begin_lock;
  logic after_lock;
  logic begin_exp;
  logic go_ready;
  logic timed;

  function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [31:0] v);
    logic [TIMER_BITS-1:0] r;
    if (v == 32'd0) begin
      r = TIMER_BITS'(1);
    end else if (64'(v) > 64'(TMAX)) begin
      r = TMAX;
    end else begin
      r = TIMER_BITS'(v);
    end
    return r;
  endfunction

  always_comb begin
    phase_next  = phase;
    timer_next  = timer;
    count_next  = count;
    enter_stage = 1'b0;
    begin_lock  = 1'b0;
    after_lock  = 1'b0;
    begin_exp   = 1'b0;
    go_ready    = 1'b0;
    timed       = (phase == PH_LDELAY) || (phase == PH_SDELAY) || (phase == PH_EXPOSE);
    rsp         = '0;

    case (req.op)
      OP_START: begin
        if (phase == PH_READY) begin
          count_next   = '0;
          rsp.cmd_init = 1'b1;
          if (!req.camera_ready) begin
            rsp.sequence_end = 1'b1;
          end else if (cfg.lockup_enable) begin
            enter_stage = 1'b1;
          end else begin
            after_lock = 1'b1;
          end
        end
      end
      OP_ABORT: begin
        if (phase != PH_READY) begin
          if (phase == PH_EXPOSE) begin
            rsp.cmd_end_shoot = 1'b1;
            rsp.frame_done    = DONE_ABORT;
          end
          rsp.cmd_term_lockup = cfg.lockup_enable;
          go_ready            = 1'b1;
        end
      end
      OP_TICK: begin
        if (timed) begin
          if (timer > TIMER_BITS'(1)) begin
            timer_next = timer - TIMER_BITS'(1);
          end else begin
            timer_next = '0;
            if (phase == PH_LDELAY) begin
              begin_lock = 1'b1;
            end else if (phase == PH_SDELAY) begin
              begin_exp = 1'b1;
            end else begin
              rsp.cmd_end_shoot = 1'b1;
              rsp.frame_done    = DONE_OK;
              count_next        = count + FRAME_BITS'(1);
              if (count_next == FRAME_BITS'(cfg.frame_total)) begin
                rsp.cmd_term_lockup = cfg.lockup_enable;
                go_ready            = 1'b1;
              end else if (cfg.lockup_enable && cfg.lockup_every_frame) begin
                rsp.cmd_term_lockup = 1'b1;
                enter_stage         = 1'b1;
              end else begin
                after_lock = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase

    if (enter_stage) begin
      if (cfg.lockup_delay_ms != 32'd0) begin
        phase_next = PH_LDELAY;
        timer_next = clamp_time(cfg.lockup_delay_ms);
      end else begin
        begin_lock = 1'b1;
      end
    end

    if (begin_lock) begin
      rsp.cmd_start_lockup = 1'b1;
      if (!req.lockup_ok) begin
        go_ready = 1'b1;
      end else begin
        after_lock = 1'b1;
      end
    end

    if (after_lock) begin
      if (cfg.shoot_delay_ms != 32'd0) begin
        phase_next = PH_SDELAY;
        timer_next = clamp_time(cfg.shoot_delay_ms);
      end else begin
        begin_exp = 1'b1;
      end
    end

    if (begin_exp) begin
      rsp.cmd_start_shoot = 1'b1;
      if (!req.shoot_ok) begin
        rsp.cmd_term_lockup = rsp.cmd_term_lockup | cfg.lockup_enable;
        go_ready            = 1'b1;
      end else begin
        phase_next = PH_EXPOSE;
        timer_next = clamp_time(cfg.exposure_ms);
      end
    end

    if (go_ready) begin
      rsp.cmd_term_shoot = 1'b1;
      rsp.sequence_end   = 1'b1;
      phase_next         = PH_READY;
      timer_next         = '0;
    end

    rsp.phase       = phase_next;
    rsp.frame_index = 16'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_READY;
      timer <= '0;
      count <= '0;
    end else if (advance) begin
      phase <= phase_next;
      timer <= timer_next;
      count <= count_next;
    end
  end

endmodule
